FILE: rtl/tlsm_pkg.sv
package tlsm_pkg;

	localparam int MAX_NODES       = 4096;
	localparam int MAX_PATTERN_LEN = 128;
	localparam int NAME_IDS        = 512;

	localparam int NODE_W  = $clog2(MAX_NODES);
	localparam int NUSED_W = NODE_W + 1;
	localparam int LEN_W   = 8;
	localparam int NAME_W  = 9;
	localparam int SLOT_W  = $clog2(MAX_PATTERN_LEN);
	localparam int WCNT_W  = SLOT_W + 1;

	typedef logic [NODE_W-1:0] node_id_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_LONG = 2'd2
	} status_t;

	typedef enum logic {
		KIND_INSERT   = 1'b0,
		KIND_CLASSIFY = 1'b1
	} kind_t;

	// One trie node: the byte on the edge from its parent, its next sibling,
	// its first child and its terminal mark.
	typedef struct packed {
		logic [7:0]        ch;
		logic              sib_v;
		node_id_t          sib;
		logic              first_v;
		node_id_t          first;
		logic              term_v;
		logic [NAME_W-1:0] name;
	} node_ent_t;

	typedef struct packed {
		node_id_t         node;
		logic [LEN_W-1:0] len;
	} walker_t;

	localparam int NODE_ENT_W = $bits(node_ent_t);
	localparam int WALKER_W   = $bits(walker_t);

	function automatic logic [7:0] fold(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5a) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

	function automatic logic [NAME_W-1:0] sat_name(input logic [NAME_W-1:0] n);
		logic [NAME_W-1:0] r;
		r = n;
		if (int'(n) >= NAME_IDS) begin
			r = NAME_W'(NAME_IDS - 1);
		end
		return r;
	endfunction

endpackage

FILE: rtl/tlsm_in_if.sv
interface tlsm_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] char_byte;
	logic       last_byte;
	logic [8:0] pattern_name;

	modport source (output valid, mode, char_byte, last_byte, pattern_name, input ready);
	modport sink (input valid, mode, char_byte, last_byte, pattern_name, output ready);
endinterface

FILE: rtl/tlsm_out_if.sv
interface tlsm_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [1:0] status;
	logic       matched;
	logic [8:0] match_name;
	logic [7:0] match_length;

	modport source (output valid, kind, status, matched, match_name, match_length, input ready);
	modport sink (input valid, kind, status, matched, match_name, match_length, output ready);
endinterface

FILE: rtl/tlsm_ram.sv
module tlsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end
endmodule

FILE: rtl/trie_longest_substring_match_top.sv
// Case-insensitive multi-pattern matcher on a trie.
// The req channel takes one byte per request. Mode 0 bytes build a pattern
// into the trie; the last byte marks its node terminal with the name id.
// Mode 1 bytes stream a string; the last byte ends it. Each last byte
// produces one response on rsp: an insert status, or the longest pattern
// found anywhere in the string (leftmost on ties).
// Each trie lookup scans the siblings of a node one at a time in the node
// memory. A string byte runs one lookup for every live walker (at most 128)
// and one for the walker that starts at the byte.
// Lookups share the single read port of the node memory.
// An insert byte runs one lookup; a new node is written and then linked as
// its parent's first child, and the last byte marks its node terminal.
// Reset leaves only the root node and no walkers; no clearing pass is needed.
// A finished response waits in an output register; the next request is
// taken while it waits, and the next response, and requests with it, stall behind it.
module trie_longest_substring_match_top (
	input logic        clk,
	input logic        arst_n,
	tlsm_in_if.sink    req,
	tlsm_out_if.source rsp
);
	import tlsm_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_NEXT  = 10'b0000000010,
		S_WREAD = 10'b0000000100,
		S_START = 10'b0000001000,
		S_FIRST = 10'b0000010000,
		S_SCAN  = 10'b0000100000,
		S_NEWND = 10'b0001000000,
		S_PARUP = 10'b0010000000,
		S_POST  = 10'b0100000000,
		S_TERM  = 10'b1000000000
	} state_t;

	state_t state_q;
	logic   fin_q;

	logic              mode_q;
	logic [7:0]        c_q;
	logic              last_q;
	logic [NAME_W-1:0] name_q;

	node_id_t         ins_cur_q;
	logic [LEN_W-1:0] ins_len_q;
	status_t          ins_st_q;
	logic [NUSED_W-1:0] nused_q;
	logic             root_first_v_q;
	node_id_t         root_first_q;

	logic [SLOT_W-1:0] head_q, tail_q;
	logic [WCNT_W-1:0] wcnt_q, rem_q;
	logic              root_pend_q;

	node_id_t         par_q, cand_q;
	logic [LEN_W-1:0] len_q;
	node_ent_t        par_ent_q;
	logic             term_rd_q;

	logic [LEN_W-1:0]  best_len_q;
	logic [NAME_W-1:0] best_name_q;

	logic              ov_q, o_kind_q, o_matched_q;
	logic [1:0]        o_st_q;
	logic [NAME_W-1:0] o_name_q;
	logic [LEN_W-1:0]  o_len_q;

	logic                  nd_we, nd_re;
	logic [NODE_W-1:0]     nd_waddr, nd_raddr;
	logic [NODE_ENT_W-1:0] nd_wdata, nd_rdata;
	node_ent_t             nd_rd, nd_new, nd_upd;
	logic                  wk_we, wk_re;
	logic [SLOT_W-1:0]     wk_waddr, wk_raddr;
	logic [WALKER_W-1:0]   wk_wdata, wk_rdata;
	walker_t               wk_rd, wk_push;

	logic       at_cand, cand_v, hit, miss, go_cand, fire;
	node_id_t   cand;
	logic [LEN_W-1:0] new_len;

	assign nd_rd   = node_ent_t'(nd_rdata);
	assign wk_rd   = walker_t'(wk_rdata);
	assign new_len = len_q + LEN_W'(1);
	assign fire    = !ov_q || rsp.ready;

	always_comb begin
		at_cand = 1'b0;
		cand_v  = 1'b0;
		cand    = '0;
		hit     = 1'b0;
		case (1'b1)
			state_q[3]: begin
				if (par_q == '0) begin
					at_cand = 1'b1;
					cand_v  = root_first_v_q;
					cand    = root_first_q;
				end
			end
			state_q[4]: begin
				at_cand = 1'b1;
				cand_v  = nd_rd.first_v;
				cand    = nd_rd.first;
			end
			state_q[5]: begin
				if (!term_rd_q && nd_rd.ch == c_q) begin
					hit = 1'b1;
				end else if (!term_rd_q) begin
					at_cand = 1'b1;
					cand_v  = nd_rd.sib_v;
					cand    = nd_rd.sib;
				end
			end
			default: begin
			end
		endcase
		miss    = at_cand && !cand_v;
		go_cand = at_cand && cand_v;
	end

	always_comb begin
		nd_new.ch      = c_q;
		nd_new.sib_v   = (par_q == '0) ? root_first_v_q : par_ent_q.first_v;
		nd_new.sib     = (par_q == '0) ? root_first_q : par_ent_q.first;
		nd_new.first_v = 1'b0;
		nd_new.first   = '0;
		nd_new.term_v  = 1'b0;
		nd_new.name    = '0;

		nd_upd = par_ent_q;
		if (state_q == S_PARUP) begin
			nd_upd.first_v = 1'b1;
			nd_upd.first   = nused_q[NODE_W-1:0];
		end else begin
			nd_upd        = nd_rd;
			nd_upd.term_v = 1'b1;
			nd_upd.name   = sat_name(name_q);
		end

		nd_re    = 1'b0;
		nd_raddr = cand;
		if (state_q == S_START && par_q != '0) begin
			nd_re    = 1'b1;
			nd_raddr = par_q;
		end else if (go_cand) begin
			nd_re = 1'b1;
		end else if (state_q == S_POST && last_q && ins_st_q == ST_OK) begin
			nd_re    = 1'b1;
			nd_raddr = ins_cur_q;
		end

		nd_we    = 1'b0;
		nd_waddr = par_q;
		nd_wdata = NODE_ENT_W'(nd_upd);
		if (state_q == S_NEWND) begin
			nd_we    = 1'b1;
			nd_waddr = nused_q[NODE_W-1:0];
			nd_wdata = NODE_ENT_W'(nd_new);
		end else if (state_q == S_PARUP && par_q != '0) begin
			nd_we = 1'b1;
		end else if (state_q == S_SCAN && term_rd_q) begin
			nd_we    = 1'b1;
			nd_waddr = ins_cur_q;
		end

		wk_re    = (state_q == S_NEXT) && (rem_q != '0);
		wk_raddr = head_q;
		wk_push.node = cand_q;
		wk_push.len  = new_len;
		wk_we    = hit && mode_q;
		wk_waddr = tail_q;
		wk_wdata = WALKER_W'(wk_push);
	end

	tlsm_ram #(.WIDTH(NODE_ENT_W), .DEPTH(MAX_NODES)) u_node_ram (
		.clk   (clk),
		.we    (nd_we),
		.waddr (nd_waddr),
		.wdata (nd_wdata),
		.re    (nd_re),
		.raddr (nd_raddr),
		.rdata (nd_rdata)
	);

	tlsm_ram #(.WIDTH(WALKER_W), .DEPTH(MAX_PATTERN_LEN)) u_walk_ram (
		.clk   (clk),
		.we    (wk_we),
		.waddr (wk_waddr),
		.wdata (wk_wdata),
		.re    (wk_re),
		.raddr (wk_raddr),
		.rdata (wk_rdata)
	);

	assign req.ready        = (state_q == S_IDLE) && !fin_q;
	assign rsp.valid        = ov_q;
	assign rsp.kind         = o_kind_q;
	assign rsp.status       = o_st_q;
	assign rsp.matched      = o_matched_q;
	assign rsp.match_name   = o_name_q;
	assign rsp.match_length = o_len_q;

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_q <= req.mode;
			c_q    <= fold(req.char_byte);
			last_q <= req.last_byte;
			name_q <= req.pattern_name;
		end
		if (go_cand) begin
			cand_q <= cand;
		end
		if (state_q == S_FIRST) begin
			par_ent_q <= nd_rd;
		end
		if (state_q == S_WREAD) begin
			par_q <= wk_rd.node;
			len_q <= wk_rd.len;
		end else if (state_q == S_NEXT) begin
			par_q <= '0;
			len_q <= '0;
		end else if (state_q == S_IDLE) begin
			par_q <= ins_cur_q;
		end
		if (fin_q && fire) begin
			o_kind_q <= mode_q;
			if (mode_q == KIND_CLASSIFY) begin
				o_st_q      <= ST_OK;
				o_matched_q <= (best_len_q != '0);
				o_name_q    <= best_name_q;
				o_len_q     <= best_len_q;
			end else begin
				o_st_q      <= ins_st_q;
				o_matched_q <= 1'b0;
				o_name_q    <= '0;
				o_len_q     <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			fin_q          <= 1'b0;
			ins_cur_q      <= '0;
			ins_len_q      <= '0;
			ins_st_q       <= ST_OK;
			nused_q        <= NUSED_W'(1);
			root_first_v_q <= 1'b0;
			root_first_q   <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			wcnt_q         <= '0;
			rem_q          <= '0;
			root_pend_q    <= 1'b0;
			term_rd_q      <= 1'b0;
			best_len_q     <= '0;
			best_name_q    <= '0;
			ov_q           <= 1'b0;
		end else begin
			if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			if (fin_q && fire) begin
				ov_q  <= 1'b1;
				fin_q <= 1'b0;
				if (mode_q == KIND_CLASSIFY) begin
					head_q      <= '0;
					tail_q      <= '0;
					wcnt_q      <= '0;
					best_len_q  <= '0;
					best_name_q <= '0;
				end else begin
					ins_cur_q <= '0;
					ins_len_q <= '0;
					ins_st_q  <= ST_OK;
				end
			end

			if (hit && mode_q) begin
				tail_q <= tail_q + SLOT_W'(1);
				wcnt_q <= wcnt_q + ((state_q == S_SCAN) ? WCNT_W'(1) : WCNT_W'(0));
				if (nd_rd.term_v && new_len > best_len_q) begin
					best_len_q  <= new_len;
					best_name_q <= nd_rd.name;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						if (req.mode == KIND_CLASSIFY) begin
							rem_q       <= wcnt_q;
							root_pend_q <= 1'b1;
							state_q     <= S_NEXT;
						end else if (ins_st_q != ST_OK) begin
							state_q <= S_POST;
						end else if (ins_len_q >= LEN_W'(MAX_PATTERN_LEN)) begin
							ins_st_q <= ST_LONG;
							state_q  <= S_POST;
						end else begin
							state_q <= S_START;
						end
					end
				end
				S_NEXT: begin
					if (rem_q != '0) begin
						state_q <= S_WREAD;
					end else if (root_pend_q) begin
						root_pend_q <= 1'b0;
						state_q     <= S_START;
					end else begin
						fin_q   <= last_q;
						state_q <= S_IDLE;
					end
				end
				S_WREAD: begin
					head_q  <= head_q + SLOT_W'(1);
					rem_q   <= rem_q - WCNT_W'(1);
					wcnt_q  <= wcnt_q - WCNT_W'(1);
					state_q <= S_START;
				end
				S_START, S_FIRST, S_SCAN: begin
					if (state_q == S_SCAN && term_rd_q) begin
						term_rd_q <= 1'b0;
						fin_q     <= 1'b1;
						state_q   <= S_IDLE;
					end else if (state_q == S_START && par_q != '0) begin
						state_q <= S_FIRST;
					end else if (go_cand) begin
						state_q <= S_SCAN;
					end else if (hit) begin
						if (mode_q == KIND_CLASSIFY) begin
							state_q <= S_NEXT;
						end else begin
							ins_cur_q <= cand_q;
							ins_len_q <= ins_len_q + LEN_W'(1);
							state_q   <= S_POST;
						end
					end else if (miss) begin
						if (mode_q == KIND_CLASSIFY) begin
							state_q <= S_NEXT;
						end else if (nused_q >= NUSED_W'(MAX_NODES)) begin
							ins_st_q <= ST_FULL;
							state_q  <= S_POST;
						end else begin
							state_q <= S_NEWND;
						end
					end
				end
				S_NEWND: begin
					state_q <= S_PARUP;
				end
				S_PARUP: begin
					if (par_q == '0) begin
						root_first_v_q <= 1'b1;
						root_first_q   <= nused_q[NODE_W-1:0];
					end
					ins_cur_q <= nused_q[NODE_W-1:0];
					ins_len_q <= ins_len_q + LEN_W'(1);
					nused_q   <= nused_q + NUSED_W'(1);
					state_q   <= S_POST;
				end
				S_POST: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (ins_st_q == ST_OK) begin
						state_q <= S_TERM;
					end else begin
						fin_q   <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_TERM: begin
					term_rd_q <= 1'b1;
					state_q   <= S_SCAN;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
